[hw/rtl/sbsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial bank switch mapper package
// Shared codes, field widths and the beat and control structs of the mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    localparam int unsigned CmdW     = 2;
    localparam int unsigned AddrW    = 16;
    localparam int unsigned DataW    = 8;
    localparam int unsigned MappedW  = 18;
    localparam int unsigned PrgMaskW = 18;
    localparam int unsigned ChrMaskW = 17;
    localparam int unsigned CountW   = 5;
    localparam int unsigned CfgDataW = 18;
    localparam int unsigned CfgIdxW  = 2;

    // Kind of bus access carried by one input beat.
    typedef enum logic [CmdW-1:0] {
        CMD_CPU_READ  = 2'd0,
        CMD_CPU_WRITE = 2'd1,
        CMD_PPU_READ  = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    // Memory that serves an access.
    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_ROM = 2'd1,
        TGT_PRG_RAM = 2'd2,
        TGT_CHR     = 2'd3
    } target_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRG_BANK_COUNT = 2'd0,
        CFG_PRG_ADDR_MASK  = 2'd1,
        CFG_CHR_ADDR_MASK  = 2'd2,
        CFG_CHR_PRESENT    = 2'd3
    } cfg_idx_t;

    // Internal register picked by address bits 14:13 on a serial commit.
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } bank_sel_t;

    // PRG banking modes in control bits 3:2.
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // Serial shift register: empty state holds only the marker bit.
    localparam logic [5:0] SHIFT_EMPTY   = 6'b100000;
    localparam logic [4:0] CONTROL_RESET = 5'h0C;

    typedef struct packed {
        cmd_t             command;
        logic [AddrW-1:0] address;
        logic [DataW-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic               hit;
        target_t            target;
        logic [MappedW-1:0] mapped_addr;
        logic [1:0]         mirror_mode;
    } result_t;

    // Bank state handed from the register file to the address map.
    typedef struct packed {
        logic [3:0]          prg_bank0;
        logic [3:0]          prg_bank1;
        logic [4:0]          chr_bank0;
        logic [4:0]          chr_bank1;
        logic                ram_enabled;
        logic                chr_present;
        logic [PrgMaskW-1:0] prg_addr_mask;
        logic [ChrMaskW-1:0] chr_addr_mask;
        logic [1:0]          mirroring_next;
    } map_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/sbsm_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper register file
// Serial shift loader, bank and control registers, configuration registers
// and the 16KB/4KB bank selection derived from them.
// ----------------------------------------------------------------------------
module sbsm_regs
    import sbsm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wr_data,
    input  wire logic                step_en,
    input  wire item_t               item,
    output map_ctrl_t                ctrl
);

    logic [5:0]          shift_reg, shift_next;
    logic [4:0]          control_reg, control_next;
    logic [4:0]          chr_low_reg, chr_low_next;
    logic [4:0]          chr_high_reg, chr_high_next;
    logic [3:0]          prg_bank_reg, prg_bank_next;
    logic                ram_en_reg, ram_en_next;
    logic                blocked_reg, blocked_next;
    logic [1:0]          mirror_reg, mirror_next;
    logic [CountW-1:0]   bank_count_reg;
    logic [PrgMaskW-1:0] prg_mask_reg;
    logic [ChrMaskW-1:0] chr_mask_reg;
    logic                chr_present_reg;

    logic [5:0]  shifted;
    logic [4:0]  commit_val;
    logic [4:0]  last_idx;
    logic [3:0]  last_bank;
    bank_sel_t   sel;

    assign shifted    = {item.write_data[0], shift_reg[5:1]};
    assign commit_val = shifted[5:1];
    assign sel        = bank_sel_t'(item.address[14:13]);

    // Serial loader and bank register updates for one access.
    always_comb begin
        shift_next    = shift_reg;
        control_next  = control_reg;
        chr_low_next  = chr_low_reg;
        chr_high_next = chr_high_reg;
        prg_bank_next = prg_bank_reg;
        ram_en_next   = ram_en_reg;
        blocked_next  = blocked_reg;
        mirror_next   = mirror_reg;
        if (step_en) begin
            if (item.command == CMD_CPU_READ) begin
                blocked_next = 1'b0;
            end else if (item.command == CMD_CPU_WRITE && item.address[15] && !blocked_reg) begin
                if (item.write_data[7]) begin
                    // Reset write: clear the loader and force the fixed-last PRG mode.
                    shift_next   = SHIFT_EMPTY;
                    control_next = control_reg | CONTROL_RESET;
                    blocked_next = 1'b1;
                end else if (shifted[0]) begin
                    // Marker reached bit 0: five bits are in, commit them.
                    shift_next = SHIFT_EMPTY;
                    case (sel)
                        SEL_CONTROL: begin
                            control_next = commit_val;
                            mirror_next  = commit_val[1:0];
                        end
                        SEL_CHR_LOW:  chr_low_next  = commit_val;
                        SEL_CHR_HIGH: chr_high_next = commit_val;
                        SEL_PRG: begin
                            prg_bank_next = commit_val[3:0];
                            ram_en_next   = !commit_val[4];
                        end
                        default: shift_next = SHIFT_EMPTY;
                    endcase
                end else begin
                    shift_next = shifted;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= SHIFT_EMPTY;
            control_reg  <= CONTROL_RESET;
            chr_low_reg  <= '0;
            chr_high_reg <= '0;
            prg_bank_reg <= '0;
            ram_en_reg   <= 1'b1;
            blocked_reg  <= 1'b0;
            mirror_reg   <= '0;
        end else begin
            shift_reg    <= shift_next;
            control_reg  <= control_next;
            chr_low_reg  <= chr_low_next;
            chr_high_reg <= chr_high_next;
            prg_bank_reg <= prg_bank_next;
            ram_en_reg   <= ram_en_next;
            blocked_reg  <= blocked_next;
            mirror_reg   <= mirror_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_count_reg  <= CountW'(2);
            prg_mask_reg    <= PrgMaskW'(18'h07FFF);
            chr_mask_reg    <= ChrMaskW'(17'h01FFF);
            chr_present_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRG_BANK_COUNT: bank_count_reg  <= cfg_wr_data[CountW-1:0];
                CFG_PRG_ADDR_MASK:  prg_mask_reg    <= cfg_wr_data[PrgMaskW-1:0];
                CFG_CHR_ADDR_MASK:  chr_mask_reg    <= cfg_wr_data[ChrMaskW-1:0];
                CFG_CHR_PRESENT:    chr_present_reg <= cfg_wr_data[0];
                default:            chr_present_reg <= chr_present_reg;
            endcase
        end
    end

    // Last bank index wraps to four bits; an empty count means bank zero.
    assign last_idx  = bank_count_reg - 5'd1;
    assign last_bank = (bank_count_reg == '0) ? 4'd0 : last_idx[3:0];

    // Bank numbers for each 16KB PRG window and each 4KB CHR window.
    always_comb begin
        case (control_reg[3:2])
            PRG_MODE_FIX_FIRST: begin
                ctrl.prg_bank0 = 4'd0;
                ctrl.prg_bank1 = prg_bank_reg;
            end
            PRG_MODE_FIX_LAST: begin
                ctrl.prg_bank0 = prg_bank_reg;
                ctrl.prg_bank1 = last_bank;
            end
            default: begin
                ctrl.prg_bank0 = {prg_bank_reg[3:1], 1'b0};
                ctrl.prg_bank1 = {prg_bank_reg[3:1], 1'b1};
            end
        endcase
        if (control_reg[4]) begin
            ctrl.chr_bank0 = chr_low_reg;
            ctrl.chr_bank1 = chr_high_reg;
        end else begin
            ctrl.chr_bank0 = {chr_low_reg[4:1], 1'b0};
            ctrl.chr_bank1 = {chr_low_reg[4:1], 1'b1};
        end
        ctrl.ram_enabled    = ram_en_reg;
        ctrl.chr_present    = chr_present_reg;
        ctrl.prg_addr_mask  = prg_mask_reg;
        ctrl.chr_addr_mask  = chr_mask_reg;
        ctrl.mirroring_next = mirror_next;
    end

endmodule
`default_nettype wire

[hw/rtl/sbsm_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper address decode
// Decodes one bus access into hit, target memory, mapped byte address and mirroring mode.
// ----------------------------------------------------------------------------
module sbsm_map
    import sbsm_pkg::*;
(
    input  wire item_t     item,
    input  wire map_ctrl_t ctrl,
    output result_t        result
);

    logic [3:0]          prg_bank;
    logic [4:0]          chr_bank;
    logic [PrgMaskW-1:0] prg_addr;
    logic [ChrMaskW-1:0] chr_addr;
    logic                in_ram;

    assign prg_bank = item.address[14] ? ctrl.prg_bank1 : ctrl.prg_bank0;
    assign chr_bank = item.address[12] ? ctrl.chr_bank1 : ctrl.chr_bank0;
    assign prg_addr = {prg_bank, item.address[13:0]} & ctrl.prg_addr_mask;
    assign chr_addr = {chr_bank, item.address[11:0]} & ctrl.chr_addr_mask;
    assign in_ram   = (item.address[15:13] == 3'b011);

    always_comb begin
        result.hit         = 1'b0;
        result.target      = TGT_NONE;
        result.mapped_addr = '0;
        result.mirror_mode = ctrl.mirroring_next;
        case (item.command)
            CMD_CPU_READ: begin
                if (item.address[15]) begin
                    result.hit         = 1'b1;
                    result.target      = TGT_PRG_ROM;
                    result.mapped_addr = prg_addr;
                end else if (in_ram && ctrl.ram_enabled) begin
                    result.hit         = 1'b1;
                    result.target      = TGT_PRG_RAM;
                    result.mapped_addr = MappedW'(item.address[12:0]);
                end
            end
            CMD_CPU_WRITE: begin
                // RAM writes are served regardless of the enable bit.
                if (in_ram) begin
                    result.hit         = 1'b1;
                    result.target      = TGT_PRG_RAM;
                    result.mapped_addr = MappedW'(item.address[12:0]);
                end
            end
            CMD_PPU_READ: begin
                if (item.address[15:13] == 3'b000 && ctrl.chr_present) begin
                    result.hit         = 1'b1;
                    result.target      = TGT_CHR;
                    result.mapped_addr = MappedW'(chr_addr);
                end
            end
            default: result.hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/serial_bank_switch_mapper_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial bank switch mapper core
// Cartridge mapper with a 5-bit serial bank loader, streaming access port.
// ----------------------------------------------------------------------------
// Each input beat is one bus access (CPU read, CPU write or PPU read) and
// produces exactly one result beat with hit, target memory, mapped address
// and the current mirroring mode. CPU writes at 0x8000 and above load the
// serial register and update the bank state as part of the same access.
// The access is captured in an input register, decoded against the bank
// registers, and the result lands in an output register while the bank
// state updates. Throughput is one beat per cycle while m_tready stays
// high; the input register and the output register each advance whenever
// the stage after them is free. When the receiver stalls, the output
// register holds its beat, the input register fills, and s_tready drops
// until m_tready returns. Reset clears both pipeline stages and loads the
// bank and configuration registers with their power-on values. The user
// must make configuration writes only while no beat is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core
    import sbsm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration write port.
    input  wire logic                cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wr_data,
    // Access stream.
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [23:0]         s_tdata,   // address[15:0], write_data[23:16]
    input  wire logic [CmdW-1:0]     s_tuser,   // command[1:0]
    // Result stream.
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [23:0]         m_tdata,   // mapped_addr[17:0], mirror_mode[19:18]
    output      logic [2:0]          m_tuser    // hit[0], target[2:1]
);

    logic      in_valid_reg, in_valid_next;
    item_t     in_item_reg;
    logic      out_valid_reg, out_valid_next;
    result_t   out_result_reg;
    logic      s_accept;
    logic      step_en;
    map_ctrl_t ctrl;
    result_t   result;

    // The input stage moves on whenever the output register is free.
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command    <= cmd_t'(s_tuser);
            in_item_reg.address    <= s_tdata[15:0];
            in_item_reg.write_data <= s_tdata[23:16];
        end
        if (step_en) begin
            out_result_reg <= result;
        end
    end

    sbsm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .item        (in_item_reg),
        .ctrl        (ctrl)
    );

    sbsm_map u_map (
        .item   (in_item_reg),
        .ctrl   (ctrl),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_result_reg.mirror_mode, out_result_reg.mapped_addr};
    assign m_tuser  = {out_result_reg.target, out_result_reg.hit};

endmodule
`default_nettype wire

[verif/serial_bank_switch_mapper_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial bank switch mapper core testbench
// Drives bus accesses through the access stream, keeps its own copy of the
// serial loader and bank state, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core_tb;
    import sbsm_pkg::*;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          PHASE_ITEMS  = 250;
    localparam int          PHASE_COUNT  = 7;
    localparam logic [15:0] ROM_BASE     = 16'h8000;
    localparam logic [15:0] RAM_BASE     = 16'h6000;
    localparam logic [15:0] PATTERN_TOP  = 16'h2000;
    localparam logic [7:0]  RESET_WRITE  = 8'h80;

    // One row of the directed table; want is used only when fixed is set.
    typedef struct packed {
        item_t   acc;
        logic    fixed;
        result_t want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = CFG_PRG_BANK_COUNT;
    logic [CfgDataW-1:0] cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata = '0;
    logic [CmdW-1:0]     s_tuser = CMD_CPU_READ;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [23:0]         m_tdata;
    logic [2:0]          m_tuser;

    serial_bank_switch_mapper_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Mapper state as this bench expects it.
    logic [4:0]  bank_count;
    logic [17:0] prg_mask;
    logic [16:0] chr_mask;
    logic        chr_on;
    logic [5:0]  shifter;
    logic [4:0]  control;
    logic [4:0]  chr_lo;
    logic [4:0]  chr_hi;
    logic [3:0]  prg_sel;
    logic        ram_on;
    logic        writes_blocked;
    logic [1:0]  mirroring;

    result_t pending_results[$];
    int      error_count = 0;
    int      sent_count = 0;
    int      cycle_count = 0;
    int      rom_hits = 0;
    int      ram_hits = 0;
    int      chr_hits = 0;
    int      misses = 0;
    bit      tx_idle = 1'b0;
    bit      rx_idle = 1'b0;
    int      rx_hold = 0;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Base of the 16KB PRG window picked by CPU address bit 14.
    function automatic logic [17:0] prg_base(input logic upper);
        logic [17:0] last_bank;
        last_bank = (bank_count == 5'd0) ? 18'd0 : 18'((bank_count - 5'd1) * 18'h4000);
        case (control[3:2])
            PRG_MODE_FIX_FIRST: return upper ? {prg_sel, 14'd0} : 18'd0;
            PRG_MODE_FIX_LAST:  return upper ? last_bank : {prg_sel, 14'd0};
            default:            return {prg_sel[3:1], upper, 14'd0};
        endcase
    endfunction

    // Base of the 4KB CHR window picked by PPU address bit 12.
    function automatic logic [16:0] chr_base(input logic upper);
        logic [4:0] page;
        page = control[4] ? (upper ? chr_hi : chr_lo) : {chr_lo[4:1], upper};
        return {page, 12'd0};
    endfunction

    task automatic mapper_reset();
        bank_count     = 5'd2;
        prg_mask       = 18'h07FFF;
        chr_mask       = 17'h01FFF;
        chr_on         = 1'b1;
        shifter        = SHIFT_EMPTY;
        control        = CONTROL_RESET;
        chr_lo         = '0;
        chr_hi         = '0;
        prg_sel        = '0;
        ram_on         = 1'b1;
        writes_blocked = 1'b0;
        mirroring      = '0;
    endtask

    // Apply one access to the expected state and return the result it gives.
    task automatic map_access(input item_t it, output result_t r);
        logic [5:0] next_shift;
        logic [4:0] value;
        r = '0;
        case (it.command)
            CMD_CPU_READ: begin
                writes_blocked = 1'b0;
                if (it.address >= ROM_BASE) begin
                    r.hit = 1'b1;
                    r.target = TGT_PRG_ROM;
                    r.mapped_addr = ({4'd0, it.address[13:0]} | prg_base(it.address[14]))
                                    & prg_mask;
                end else if (it.address >= RAM_BASE && ram_on) begin
                    r.hit = 1'b1;
                    r.target = TGT_PRG_RAM;
                    r.mapped_addr = {5'd0, it.address[12:0]};
                end
            end
            CMD_CPU_WRITE: begin
                if (it.address < ROM_BASE) begin
                    // Save RAM writes go through whatever the enable bit says.
                    if (it.address >= RAM_BASE) begin
                        r.hit = 1'b1;
                        r.target = TGT_PRG_RAM;
                        r.mapped_addr = {5'd0, it.address[12:0]};
                    end
                end else if (!writes_blocked) begin
                    if (it.write_data[7]) begin
                        shifter = SHIFT_EMPTY;
                        control = control | CONTROL_RESET;
                        writes_blocked = 1'b1;
                    end else begin
                        next_shift = {it.write_data[0], shifter[5:1]};
                        if (next_shift[0]) begin
                            // Fifth bit: the marker has reached bit 0, commit.
                            value = next_shift[5:1];
                            case (bank_sel_t'(it.address[14:13]))
                                SEL_CONTROL: begin
                                    control = value;
                                    mirroring = value[1:0];
                                end
                                SEL_CHR_LOW:  chr_lo = value;
                                SEL_CHR_HIGH: chr_hi = value;
                                default: begin
                                    prg_sel = value[3:0];
                                    ram_on = ~value[4];
                                end
                            endcase
                            shifter = SHIFT_EMPTY;
                        end else begin
                            shifter = next_shift;
                        end
                    end
                end
            end
            CMD_PPU_READ: begin
                if (it.address < PATTERN_TOP && chr_on) begin
                    r.hit = 1'b1;
                    r.target = TGT_CHR;
                    r.mapped_addr = {1'b0, ({5'd0, it.address[11:0]}
                                    | chr_base(it.address[12])) & chr_mask};
                end
            end
            default: ;
        endcase
        r.mirror_mode = mirroring;
    endtask

    // Send one beat after an optional gap; called and left at a falling edge.
    task automatic send_access(input item_t it, input logic fixed, input result_t typed);
        result_t r;
        int      gap;
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.write_data, it.address};
        s_tuser  <= it.command;
        do @(posedge aclk); while (!s_tready);
        map_access(it, r);
        pending_results.push_back(fixed ? typed : r);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic access(input cmd_t c, input logic [15:0] a, input logic [7:0] d);
        item_t it;
        it.command = c;
        it.address = a;
        it.write_data = d;
        send_access(it, 1'b0, '0);
    endtask

    // A read that mostly lands in a mapped window.
    task automatic random_read();
        logic [15:0] a;
        if ($urandom_range(0, 1) == 0) begin
            a = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(RAM_BASE, 16'hFFFF))
                                           : 16'($urandom);
            access(CMD_CPU_READ, a, 8'($urandom));
        end else begin
            a = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, PATTERN_TOP - 1))
                                           : 16'($urandom);
            access(CMD_PPU_READ, a, 8'($urandom));
        end
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write all four registers back to back; the bench is idle here.
    task automatic write_settings(input logic [17:0] count_v, input logic [17:0] prg_v,
                                  input logic [17:0] chr_v, input logic [17:0] present_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_wr_data <= count_v;
        @(negedge aclk);
        cfg_index <= CFG_PRG_ADDR_MASK;
        cfg_wr_data <= prg_v;
        @(negedge aclk);
        cfg_index <= CFG_CHR_ADDR_MASK;
        cfg_wr_data <= chr_v;
        @(negedge aclk);
        cfg_index <= CFG_CHR_PRESENT;
        cfg_wr_data <= present_v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        bank_count = count_v[4:0];
        prg_mask = prg_v;
        chr_mask = chr_v[16:0];
        chr_on = present_v[0];
    endtask

    // Mostly well-formed serial loads with reads between them, plus noise.
    task automatic run_random(input int n);
        int          start;
        int          pick;
        int          len;
        logic [1:0]  sel;
        logic [4:0]  value;
        logic [15:0] a;
        start = sent_count;
        while (sent_count - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 4) == 0) begin
                    access(CMD_CPU_WRITE, ROM_BASE | 16'($urandom), RESET_WRITE | 8'($urandom));
                    if ($urandom_range(0, 5) != 0)
                        access(CMD_CPU_READ, 16'($urandom), 8'($urandom));
                end
                // A few loads are cut short and leave the shifter half full.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 5;
                sel = 2'($urandom);
                value = 5'($urandom);
                for (int k = 0; k < len; k++) begin
                    a = (k == 4) ? {1'b1, sel, 13'($urandom)} : (ROM_BASE | 16'($urandom));
                    access(CMD_CPU_WRITE, a, {1'b0, 6'($urandom), value[k]});
                    if ($urandom_range(0, 5) == 0)
                        random_read();
                end
                repeat ($urandom_range(1, 5)) random_read();
            end else if (pick < 90) begin
                random_read();
            end else begin
                access(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    function automatic row_t row(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                                 input logic fixed, input logic h, input target_t t,
                                 input logic [17:0] m);
        row_t x;
        x.acc.command = c;
        x.acc.address = a;
        x.acc.write_data = d;
        x.fixed = fixed;
        x.want.hit = h;
        x.want.target = t;
        x.want.mapped_addr = m;
        x.want.mirror_mode = 2'd0;
        return x;
    endfunction

    // Receiver side: random stalls while rx_idle is set.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_idle && (($urandom_range(0, 99) < 35))) begin
            rx_hold = gap_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result beat against the oldest expectation.
    always @(posedge aclk) begin : result_check
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.hit = m_tuser[0];
            seen.target = target_t'(m_tuser[2:1]);
            seen.mapped_addr = m_tdata[17:0];
            seen.mirror_mode = m_tdata[19:18];
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending: %h / %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (seen.hit != want.hit) begin
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, seen.hit);
                    error_count++;
                end
                if (seen.target != want.target) begin
                    $display("%0t: target expected %0d got %0d",
                             $time, want.target, seen.target);
                    error_count++;
                end
                if (seen.mapped_addr != want.mapped_addr) begin
                    $display("%0t: mapped_addr expected %h got %h",
                             $time, want.mapped_addr, seen.mapped_addr);
                    error_count++;
                end
                if (seen.mirror_mode != want.mirror_mode) begin
                    $display("%0t: mirror_mode expected %0d got %0d",
                             $time, want.mirror_mode, seen.mirror_mode);
                    error_count++;
                end
                if (!seen.hit)
                    misses++;
                else if (seen.target == TGT_PRG_ROM)
                    rom_hits++;
                else if (seen.target == TGT_PRG_RAM)
                    ram_hits++;
                else
                    chr_hits++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results pending",
                     $time, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        row_t        dir_rows[25];
        logic [17:0] count_v;
        logic [17:0] prg_v;
        logic [17:0] chr_v;
        logic [17:0] present_v;

        // Power-on values are typed in; later rows follow the bank state.
        dir_rows[0]  = row(CMD_CPU_READ,  16'h8000, 8'h00, 1'b1, 1'b1, TGT_PRG_ROM, 18'h00000);
        dir_rows[1]  = row(CMD_CPU_READ,  16'hFFFF, 8'h00, 1'b1, 1'b1, TGT_PRG_ROM, 18'h07FFF);
        dir_rows[2]  = row(CMD_CPU_READ,  16'h6000, 8'h00, 1'b1, 1'b1, TGT_PRG_RAM, 18'h00000);
        dir_rows[3]  = row(CMD_CPU_READ,  16'h7FFF, 8'hFF, 1'b1, 1'b1, TGT_PRG_RAM, 18'h01FFF);
        dir_rows[4]  = row(CMD_CPU_READ,  16'h5FFF, 8'h00, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        dir_rows[5]  = row(CMD_CPU_WRITE, 16'h6ABC, 8'h55, 1'b1, 1'b1, TGT_PRG_RAM, 18'h00ABC);
        dir_rows[6]  = row(CMD_CPU_WRITE, 16'h0000, 8'hFF, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        dir_rows[7]  = row(CMD_PPU_READ,  16'h0000, 8'h00, 1'b1, 1'b1, TGT_CHR,     18'h00000);
        dir_rows[8]  = row(CMD_PPU_READ,  16'h1FFF, 8'h00, 1'b1, 1'b1, TGT_CHR,     18'h01FFF);
        dir_rows[9]  = row(CMD_PPU_READ,  16'h2000, 8'h00, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        dir_rows[10] = row(CMD_NONE,      16'hFFFF, 8'hFF, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        // Reset write, then a write that the block must ignore until a CPU read.
        dir_rows[11] = row(CMD_CPU_WRITE, 16'h8000, 8'h80, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        dir_rows[12] = row(CMD_CPU_WRITE, 16'hFFFF, 8'h01, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        dir_rows[13] = row(CMD_CPU_READ,  16'h0000, 8'h00, 1'b1, 1'b0, TGT_NONE,    18'h00000);
        // Serial load of 0x13 into control: 4KB CHR, 32KB PRG, horizontal mirroring.
        dir_rows[14] = row(CMD_CPU_WRITE, 16'h8000, 8'h41, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[15] = row(CMD_CPU_WRITE, 16'h8000, 8'h7F, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[16] = row(CMD_CPU_WRITE, 16'h8000, 8'h00, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[17] = row(CMD_CPU_WRITE, 16'h8000, 8'h7E, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[18] = row(CMD_CPU_WRITE, 16'h8000, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        // Serial load of 0x1F into the PRG register: top bank, save RAM off.
        dir_rows[19] = row(CMD_CPU_WRITE, 16'hE000, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[20] = row(CMD_CPU_WRITE, 16'hE000, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[21] = row(CMD_CPU_WRITE, 16'hE000, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[22] = row(CMD_CPU_WRITE, 16'hE000, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[23] = row(CMD_CPU_WRITE, 16'hFFFF, 8'h01, 1'b0, 1'b0, TGT_NONE, '0);
        dir_rows[24] = row(CMD_CPU_READ,  16'h6000, 8'h00, 1'b0, 1'b0, TGT_NONE, '0);

        mapper_reset();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_access(dir_rows[i].acc, dir_rows[i].fixed, dir_rows[i].want);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain();
            // Register settings: power-on values first, then extremes and random mixes.
            case (p)
                1: begin count_v = 18'd16; prg_v = 18'h3FFFF; chr_v = 18'h1FFFF; present_v = 18'd1; end
                2: begin count_v = 18'd0;  prg_v = 18'h00000; chr_v = 18'h00000; present_v = 18'd0; end
                3: begin count_v = 18'd1;  prg_v = 18'h1FFFF; chr_v = 18'h00FFF; present_v = 18'd1; end
                4: begin count_v = 18'h3FFFF; prg_v = 18'h3FFFF; chr_v = 18'h3FFFF;
                         present_v = 18'h3FFFF; end
                default: begin
                    count_v = 18'($urandom_range(1, 16));
                    prg_v = 18'($urandom);
                    chr_v = 18'($urandom) & 18'h1FFFF;
                    present_v = 18'd1;
                end
            endcase
            if (p > 0)
                write_settings(count_v, prg_v, chr_v, present_v);
            tx_idle = (p % 3) != 0;
            rx_idle = (p % 4) != 0;
            if (p == 3) begin
                run_random(PHASE_ITEMS / 2);
                drain();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d accesses over %0d register settings, %0d cycles.",
                 sent_count, PHASE_COUNT, cycle_count);
        $display("Results: %0d PRG ROM, %0d PRG RAM, %0d CHR hits, %0d misses.",
                 rom_hits, ram_hits, chr_hits, misses);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sbsm_pkg.sv
hw/rtl/sbsm_regs.sv
hw/rtl/sbsm_map.sv
hw/rtl/serial_bank_switch_mapper_core.sv
verif/serial_bank_switch_mapper_core_tb.sv
